// File: src/pcxrle_pkg.sv
// Shared types and constants of the PCX run-length decoder.
// Depends on nothing; every module of the decoder imports it.
package pcxrle_pkg;

  // Fixed field widths of the ports.
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_W     = 22;
  localparam int BYTE_W     = 8;
  localparam int RUN_W      = 6;
  localparam int NP_W       = 3;

  // A byte at or above this value is a run code.
  localparam logic [BYTE_W-1:0] RUN_BASE = 8'd192;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd3;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_WRITE
  } dec_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // latch the input beat and update the decode state
    logic emit;   // load one write into the output register
    logic close;  // finish the item: end the line if it is full
  } dec_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic starts_run;  // the offered beat leads to write work
    logic slot_free;   // the output register can take a write this cycle
    logic can_write;   // the current line still has room
    logic last_write;  // the write now possible is the last of the item
  } dec_stat_t;

endpackage

// File: src/pcx_rle_decoder.sv
// PCX run-length decoder. Takes one payload byte per beat and gives one
// buffer write per output beat. A run code only arms a run; a literal byte
// gives one write and the value byte of a run gives its writes, and no new
// byte is taken until they are loaded. The output register loads one write per cycle
// unless the output channel stalls. Depends on pcxrle_pkg, pcxrle_ctrl and pcxrle_dp.
module pcx_rle_decoder
  import pcxrle_pkg::*;
#(
  parameter int MAX_DIM    = 1024,
  parameter int MAX_PLANES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_payload_byte,
  input  logic                  in_new_image,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     out_pixel_address,
  output logic [BYTE_W-1:0]     out_pixel_value,
  output logic                  out_run_last,
  output logic                  out_image_complete
);

  dec_cmd_t  cmd;
  dec_stat_t stat;

  // Sequencing of beats and writes.
  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Counters, addresses and the output register.
  pcxrle_dp #(
    .MAX_DIM    (MAX_DIM),
    .MAX_PLANES (MAX_PLANES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_payload_byte    (in_payload_byte),
    .in_new_image       (in_new_image),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_pixel_address  (out_pixel_address),
    .out_pixel_value    (out_pixel_value),
    .out_run_last       (out_run_last),
    .out_image_complete (out_image_complete),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule

// File: src/pcxrle_ctrl.sv
// Controller of the PCX run-length decoder: sequences input beats and writes.
// Depends on pcxrle_pkg for the state type and the command and status structs.
module pcxrle_ctrl
  import pcxrle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dec_stat_t stat,
  output dec_cmd_t  cmd
);

  dec_state_t state_r;
  dec_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && stat.starts_run) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!stat.can_write) begin
          state_nxt = ST_IDLE;
        end else if (stat.slot_free && stat.last_write) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready  = 1'b0;
    cmd.take  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.close = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_WRITE: begin
        if (!stat.can_write) begin
          // The line was already full: the item ends without a write.
          cmd.close = 1'b1;
        end else if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.close = stat.last_write;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: src/pcxrle_dp.sv
// Datapath of the PCX run-length decoder: configuration, position counters,
// address arithmetic and the output register. Depends on pcxrle_pkg.
module pcxrle_dp
  import pcxrle_pkg::*;
#(
  parameter int MAX_DIM    = 1024,
  parameter int MAX_PLANES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [BYTE_W-1:0]     in_payload_byte,
  input  logic                  in_new_image,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [ADDR_W-1:0]     out_pixel_address,
  output logic [BYTE_W-1:0]     out_pixel_value,
  output logic                  out_run_last,
  output logic                  out_image_complete,
  input  dec_cmd_t              cmd,
  output dec_stat_t             stat
);

  localparam int CW  = $clog2(MAX_DIM + 1);
  localparam int RW  = $clog2(MAX_DIM);
  localparam int PW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int BWW = CW + 2;
  localparam int PRW = RW + BWW;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] width_cfg_r;
  logic [CFG_DATA_W-1:0] height_cfg_r;
  logic [NP_W-1:0]       planes_cfg_r;
  logic [NP_W-1:0]       bpp_cfg_r;

  // Decode and position state.
  logic              expect_r;
  logic [RUN_W-1:0]  pend_r;
  logic [CW-1:0]     col_r;
  logic [PW-1:0]     plane_r;
  logic [RW-1:0]     row_r;
  logic              done_r;
  logic [RUN_W-1:0]  cnt_r;
  logic [BYTE_W-1:0] value_r;
  logic [ADDR_W-1:0] base_r;

  // Output register.
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [BYTE_W-1:0] out_value_r;
  logic              out_last_r;
  logic              out_complete_r;

  logic [CW-1:0]     w_eff;
  logic [CW-1:0]     h_eff;
  logic [NP_W-1:0]   np_eff;
  logic              bpp4;
  logic [BWW-1:0]    bw;
  logic [BWW-1:0]    col_x;
  logic              last_plane;
  logic              last_row;
  logic              eff_done;
  logic              eff_expect;
  logic [RUN_W-1:0]  eff_pend;
  logic [RW-1:0]     row_eff;
  logic [RUN_W-1:0]  take_count;
  logic              is_code;
  logic [PRW-1:0]    base_prod;
  logic [CW-1:0]     col_inc;
  logic [CW-1:0]     col_after;
  logic [ADDR_W-1:0] write_addr;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= CFG_DATA_W'(1);
      height_cfg_r <= CFG_DATA_W'(1);
      planes_cfg_r <= NP_W'(3);
      bpp_cfg_r    <= NP_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:     width_cfg_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT:    height_cfg_r <= cfg_wdata;
        REG_PLANE_COUNT:     planes_cfg_r <= cfg_wdata[NP_W-1:0];
        REG_BYTES_PER_PIXEL: bpp_cfg_r    <= cfg_wdata[NP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the width, height and plane count registers to their legal ranges.
  always_comb begin
    if (width_cfg_r == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_cfg_r) > 32'(MAX_DIM)) begin
      w_eff = CW'(MAX_DIM);
    end else begin
      w_eff = CW'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      h_eff = CW'(1);
    end else if (32'(height_cfg_r) > 32'(MAX_DIM)) begin
      h_eff = CW'(MAX_DIM);
    end else begin
      h_eff = CW'(height_cfg_r);
    end
    if (planes_cfg_r == '0) begin
      np_eff = NP_W'(1);
    end else if (32'(planes_cfg_r) > 32'(MAX_PLANES)) begin
      np_eff = NP_W'(MAX_PLANES);
    end else begin
      np_eff = planes_cfg_r;
    end
  end

  assign bpp4 = (bpp_cfg_r == NP_W'(4));

  // Stride times width and stride times column, by shift and add.
  assign bw    = bpp4 ? (BWW'(w_eff) << 2) : ((BWW'(w_eff) << 1) + BWW'(w_eff));
  assign col_x = bpp4 ? (BWW'(col_r) << 2) : ((BWW'(col_r) << 1) + BWW'(col_r));

  assign last_plane = (NP_W'(plane_r) + NP_W'(1)) >= np_eff;
  assign last_row   = (CW'(row_r) + CW'(1)) >= h_eff;

  // Decode of the offered beat, seen after an optional clear.
  assign eff_done   = in_new_image ? 1'b0 : done_r;
  assign eff_expect = in_new_image ? 1'b0 : expect_r;
  assign eff_pend   = in_new_image ? '0 : pend_r;
  assign row_eff    = in_new_image ? '0 : row_r;
  assign is_code    = (in_payload_byte >= RUN_BASE);
  assign take_count = eff_expect ? eff_pend : RUN_W'(1);

  assign stat.starts_run = eff_done ? 1'b0 :
                           (eff_expect ? (eff_pend != '0) : !is_code);

  // Row start address; one multiply, registered on the input beat.
  assign base_prod = PRW'(row_eff) * PRW'(bw);

  // Address of the write now possible.
  assign write_addr = base_r + ADDR_W'(col_x) + ADDR_W'(plane_r);

  assign col_inc   = col_r + CW'(1);
  assign col_after = cmd.emit ? col_inc : col_r;

  assign stat.slot_free  = !out_valid_r || out_ready;
  assign stat.can_write  = (col_r < w_eff);
  assign stat.last_write = (cnt_r == RUN_W'(1)) || (col_inc >= w_eff);

  // Decode state and position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= 1'b0;
      pend_r   <= '0;
      col_r    <= '0;
      plane_r  <= '0;
      row_r    <= '0;
      done_r   <= 1'b0;
    end else if (cmd.take) begin
      if (in_new_image) begin
        col_r   <= '0;
        plane_r <= '0;
        row_r   <= '0;
        done_r  <= 1'b0;
      end
      // A finished image ignores the beat; a run code arms a run.
      if (eff_done) begin
        expect_r <= eff_expect;
        pend_r   <= eff_pend;
      end else if (!eff_expect && is_code) begin
        expect_r <= 1'b1;
        pend_r   <= in_payload_byte[RUN_W-1:0];
      end else begin
        expect_r <= 1'b0;
        pend_r   <= '0;
      end
    end else if (cmd.close) begin
      // End of the item: a full line moves on to the next plane or row.
      if (col_after >= w_eff) begin
        col_r <= '0;
        if (last_plane) begin
          plane_r <= '0;
          if (last_row) begin
            row_r  <= '0;
            done_r <= 1'b1;
          end else begin
            row_r <= row_r + RW'(1);
          end
        end else begin
          plane_r <= plane_r + PW'(1);
        end
      end else begin
        col_r <= col_after;
      end
    end else if (cmd.emit) begin
      col_r <= col_after;
    end
  end

  // Item payload: run count, value and row base.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cnt_r   <= take_count;
      value_r <= in_payload_byte;
      base_r  <= ADDR_W'(base_prod);
    end else if (cmd.emit) begin
      cnt_r <= cnt_r - RUN_W'(1);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_addr_r     <= write_addr;
      out_value_r    <= value_r;
      out_last_r     <= stat.last_write;
      out_complete_r <= (col_inc >= w_eff) && last_plane && last_row;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_address  = out_addr_r;
  assign out_pixel_value    = out_value_r;
  assign out_run_last       = out_last_r;
  assign out_image_complete = out_complete_r;

endmodule

// File: src/pcxrle_chk.sv
// Port checker of the PCX run-length decoder and its bind to the top level.
// Depends on pcxrle_pkg for the field widths.
module pcxrle_chk
  import pcxrle_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_pixel_address,
  input logic [BYTE_W-1:0] out_pixel_value,
  input logic              out_run_last,
  input logic              out_image_complete
);

  // The output channel is empty after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present after reset");

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_address)
      && $stable(out_pixel_value) && $stable(out_run_last)
      && $stable(out_image_complete))
    else $error("stalled output beat changed");

  // The write that ends the image always ends the work of its input byte.
  a_complete_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_complete |-> out_run_last)
    else $error("image end on a write that is not the last of its byte");

endmodule

bind pcx_rle_decoder pcxrle_chk u_chk (.*);

// File: verif/pcx_rle_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the PCX run-length decoder: watches the config port and both
// beat channels, predicts every buffer write and compares it with the DUT.
// Depends on pcxrle_pkg for port widths, the run code base and register indexes.
module pcx_rle_checker
  import pcxrle_pkg::*;
#(
  parameter int MAX_DIM    = 1024,
  parameter int MAX_PLANES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_payload_byte,
  input  logic                  in_new_image,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [ADDR_W-1:0]     out_pixel_address,
  input  logic [BYTE_W-1:0]     out_pixel_value,
  input  logic                  out_run_last,
  input  logic                  out_image_complete,
  output int                    mismatch_count,
  output int                    pending_writes,
  output logic                  image_finished
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              complete;
  } pixel_write_t;

  // Shadow copy of the configuration registers.
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [2:0]  planes_reg;
  logic [2:0]  stride_reg;

  // Decode position.
  logic        awaiting_value;
  logic [5:0]  run_len;
  logic [10:0] col_pos;
  logic [1:0]  plane_pos;
  logic [10:0] row_pos;
  logic        done;

  pixel_write_t expected_writes[$];
  pixel_write_t got;
  pixel_write_t want;
  int           errors = 0;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic clear_position();
    awaiting_value = 1'b0;
    run_len        = '0;
    col_pos        = '0;
    plane_pos      = '0;
    row_pos        = '0;
    done           = 1'b0;
  endtask

  // Expands one payload byte into the buffer writes it causes.
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic restart);
    int unsigned  w;
    int unsigned  h;
    int unsigned  np;
    int unsigned  bpp;
    int unsigned  count;
    int unsigned  addr;
    logic         last_plane;
    logic         last_row;
    pixel_write_t wr;
    w   = clamp_dim(width_reg, MAX_DIM);
    h   = clamp_dim(height_reg, MAX_DIM);
    np  = clamp_dim(planes_reg, MAX_PLANES);
    bpp = (stride_reg == 3'd4) ? 4 : 3;
    if (restart) clear_position();
    if (done) return;

    // A run code only arms the run; its value byte does the writing.
    if (awaiting_value) begin
      count          = run_len;
      awaiting_value = 1'b0;
      run_len        = '0;
    end else if (b >= RUN_BASE) begin
      run_len        = 6'(b - RUN_BASE);
      awaiting_value = 1'b1;
      return;
    end else begin
      count = 1;
    end
    if (count == 0) return;

    last_plane = (plane_pos + 1 >= np);
    last_row   = (row_pos + 1 >= h);

    // Writes past the end of the line are dropped.
    while (count > 0 && col_pos < w) begin
      addr = row_pos * bpp * w + bpp * col_pos + plane_pos;
      col_pos++;
      count--;
      wr.addr     = addr[ADDR_W-1:0];
      wr.value    = b;
      wr.last     = (count == 0) || (col_pos >= w);
      wr.complete = (col_pos >= w) && last_plane && last_row;
      expected_writes.push_back(wr);
    end

    // A full line moves on to the next plane, then the next row.
    if (col_pos >= w) begin
      col_pos = '0;
      if (last_plane) begin
        plane_pos = '0;
        if (last_row) begin
          row_pos = '0;
          done    = 1'b1;
        end else begin
          row_pos = row_pos + 1;
        end
      end else begin
        plane_pos = plane_pos + 1;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_val, act_val);
    end
  endtask

  // Everything is sampled at the rising edge, in the order config, input, output.
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = 11'd1;
      height_reg = 11'd1;
      planes_reg = 3'd3;
      stride_reg = 3'd3;
      clear_position();
      expected_writes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:     width_reg  = cfg_wdata;
          REG_IMAGE_HEIGHT:    height_reg = cfg_wdata;
          REG_PLANE_COUNT:     planes_reg = cfg_wdata[2:0];
          REG_BYTES_PER_PIXEL: stride_reg = cfg_wdata[2:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) decode_byte(in_payload_byte, in_new_image);

      if (out_valid && out_ready) begin
        got.addr     = out_pixel_address;
        got.value    = out_pixel_value;
        got.last     = out_run_last;
        got.complete = out_image_complete;
        if (expected_writes.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected write, expected none, actual addr 0x%0h value 0x%0h",
                   $time, got.addr, got.value);
        end else begin
          want = expected_writes.pop_front();
          check_field("pixel_address", want.addr, got.addr);
          check_field("pixel_value", want.value, got.value);
          check_field("run_last", want.last, got.last);
          check_field("image_complete", want.complete, got.complete);
        end
      end
    end
    mismatch_count <= errors;
    pending_writes <= expected_writes.size();
    image_finished <= done;
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Top of the PCX run-length decoder testbench: clock, reset, config writes and
// payload stimulus, with pcx_rle_checker beside the DUT giving the verdict input.
// Depends on pcxrle_pkg, pcx_rle_decoder and pcx_rle_checker.
module tb;
  import pcxrle_pkg::*;

  localparam int RUN_LIMIT_NS  = 2_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_BEATS   = 24;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_payload_byte = '0;
  logic                  in_new_image = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ADDR_W-1:0]     out_pixel_address;
  logic [BYTE_W-1:0]     out_pixel_value;
  logic                  out_run_last;
  logic                  out_image_complete;

  int   mismatch_count;
  int   pending_writes;
  logic image_finished;

  int valid_idle_pct = 6;
  int ready_idle_pct = 49;
  int restart_pct    = 0;
  int beats_sent     = 0;

  pcx_rle_decoder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_payload_byte   (in_payload_byte),
    .in_new_image      (in_new_image),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_run_last      (out_run_last),
    .out_image_complete(out_image_complete)
  );

  pcx_rle_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_payload_byte   (in_payload_byte),
    .in_new_image      (in_new_image),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_run_last      (out_run_last),
    .out_image_complete(out_image_complete),
    .mismatch_count    (mismatch_count),
    .pending_writes    (pending_writes),
    .image_finished    (image_finished)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver stalls at random, one decision per cycle.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= ready_idle_pct);

  // Hard stop in case the DUT hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one payload beat and holds it until the DUT takes it.
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic restart);
    @(negedge clk);
    while ($urandom_range(99) < valid_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    // Once an image is finished, mostly start a fresh one instead of feeding dead bytes.
    if (image_finished && $urandom_range(99) < restart_pct) restart = 1'b1;
    in_valid        <= 1'b1;
    in_payload_byte <= b;
    in_new_image    <= restart;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Stops sending and waits until every predicted write has come out.
  task automatic drain_writes();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_writes != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drains the DUT, then programs all registers.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] np,
                               input logic [CFG_DATA_W-1:0] bpp);
    drain_writes();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_PLANE_COUNT, np);
    write_reg(REG_BYTES_PER_PIXEL, bpp);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // Mostly well-formed literals and runs, with some restarts and broken runs.
  task automatic random_traffic(input int run_cap, input bit mid_drain);
    int          start;
    int          kind;
    int          cnt;
    logic        fresh;
    logic [BYTE_W-1:0] b;
    start = beats_sent;
    while (beats_sent - start < PHASE_BEATS) begin
      // The first beat usually starts a new image; otherwise the old position carries over.
      fresh = (beats_sent == start) && ($urandom_range(4) != 0);
      kind  = $urandom_range(99);
      if (mid_drain && beats_sent - start == PHASE_BEATS / 2) drain_writes();
      if (kind < 40) begin
        b = BYTE_W'($urandom_range(RUN_BASE - 1));
        send_beat(b, fresh);
      end else if (kind < 78) begin
        cnt = $urandom_range(9);
        if (cnt == 0) cnt = 0;
        else if (cnt == 1) cnt = 63;
        else cnt = $urandom_range(run_cap, 1);
        send_beat(RUN_BASE + BYTE_W'(cnt), fresh);
        send_beat(BYTE_W'($urandom_range(255)), 1'b0);
      end else if (kind < 86) begin
        send_beat(BYTE_W'($urandom_range(255)), 1'b1);
      end else if (kind < 93) begin
        // Run code cut short by a new image.
        send_beat(RUN_BASE + BYTE_W'($urandom_range(63)), fresh);
        send_beat(BYTE_W'($urandom_range(255)), 1'b1);
      end else begin
        send_beat(BYTE_W'($urandom_range(255)), 1'(($urandom_range(1))));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset config: one pixel per line, one line, three planes, RGB stride.
    send_beat(8'hAA, 1'b0);
    send_beat(RUN_BASE + 8'd3, 1'b0);
    send_beat(8'h5A, 1'b0);
    send_beat(8'h00, 1'b0);

    // Directed: field extremes, zero run, clipped run, dead bytes, restarts.
    apply_setting(11'd3, 11'd1, 11'd2, 11'd4);
    send_beat(8'h00, 1'b1);
    send_beat(RUN_BASE - 8'd1, 1'b0);
    send_beat(RUN_BASE, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(RUN_BASE + 8'd63, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(RUN_BASE + 8'd2, 1'b0);
    send_beat(8'hC7, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h12, 1'b0);
    send_beat(RUN_BASE + 8'd1, 1'b0);
    send_beat(8'h7F, 1'b1);
    send_beat(RUN_BASE + 8'd5, 1'b0);
    send_beat(8'h01, 1'b1);

    restart_pct = 90;

    // Sender mostly busy, receiver stalling half the time.
    apply_setting(11'd1, 11'd1, 11'd1, 11'd3);
    random_traffic(1, 1'b0);
    apply_setting(11'd2047, 11'd1, 11'd4, 11'd4);
    random_traffic(63, 1'b0);
    apply_setting(11'd0, 11'd0, 11'd0, 11'd0);
    random_traffic(1, 1'b0);

    // Sender idling half the time, receiver mostly ready.
    valid_idle_pct = 49;
    ready_idle_pct = 6;
    apply_setting(11'd5, 11'd1024, 11'd7, 11'd7);
    random_traffic(5, 1'b1);
    apply_setting(11'd1024, 11'd2, 11'h402, 11'h7FC);
    random_traffic(63, 1'b0);
    apply_setting(11'd3, 11'd4, 11'd3, 11'd3);
    random_traffic(3, 1'b0);

    // Full throughput on both sides.
    valid_idle_pct = 0;
    ready_idle_pct = 0;
    apply_setting(11'd7, 11'd3, 11'd4, 11'd5);
    random_traffic(7, 1'b0);
    apply_setting(11'd1, 11'd1024, 11'd2, 11'd4);
    random_traffic(1, 1'b0);

    drain_writes();
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: pcx_rle_decoder.f
src/pcxrle_pkg.sv
src/pcxrle_ctrl.sv
src/pcxrle_dp.sv
src/pcx_rle_decoder.sv
src/pcxrle_chk.sv
verif/pcx_rle_checker.sv
verif/tb.sv
